// ===== rtl/thwgd_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// thwgd_pkg
// Shared types and constants of the converter hit word group decoder.
// ============================================================================
package thwgd_pkg;

   localparam int CHANNEL_SLOTS = 64;
   localparam int SLOT_IDX_W    = (CHANNEL_SLOTS > 1) ? $clog2(CHANNEL_SLOTS) : 1;
   localparam logic [6:0] SLOTS_LIMIT = 7'(CHANNEL_SLOTS);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 7;

   localparam logic [6:0] CHANNELS_RESET = 7'd8;
   localparam logic [3:0] HITS_RESET     = 4'd10;

   localparam logic [7:0] ROLLOVER_CODE = 8'h10;
   localparam logic [3:0] STAMP_CODE    = 4'h0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CHANNELS_IN_USE  = 1'b0,
      CSR_HITS_PER_CHANNEL = 1'b1
   } csr_index_type;

   typedef enum logic {
      RESULT_HIT     = 1'b0,
      RESULT_SUMMARY = 1'b1
   } result_kind_type;

   typedef struct packed {
      logic [6:0] channels_in_use;
      logic [3:0] hits_per_channel;
   } cfg_type;

   typedef struct packed {
      logic               has_hit;
      logic [5:0]         hit_channel;
      logic [3:0]         hit_slot;
      logic signed [23:0] hit_time;
      logic               has_sum;
      logic [63:0]        absolute_stamp;
      logic               any_hit_stored;
   } entry_type;

   typedef struct packed {
      result_kind_type    result_kind;
      logic [5:0]         hit_channel;
      logic [3:0]         hit_slot;
      logic signed [23:0] hit_time;
      logic [63:0]        absolute_stamp;
      logic               any_hit_stored;
      logic               last_of_run;
   } result_type;

endpackage

// ===== rtl/thwgd_ifs.sv =====
`timescale 1ns / 1ps
// ============================================================================
// thwgd request and response channels
// Valid/ready channels carrying converter words in and decoded results out.
// ============================================================================
interface thwgd_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] data_word;
   logic        group_end;

   modport source (output valid, output data_word, output group_end, input ready);
   modport sink   (input valid, input data_word, input group_end, output ready);
endinterface

interface thwgd_rsp_if;
   logic               valid;
   logic               ready;
   logic               result_kind;
   logic [5:0]         hit_channel;
   logic [3:0]         hit_slot;
   logic signed [23:0] hit_time;
   logic [63:0]        absolute_stamp;
   logic               any_hit_stored;
   logic               last_of_run;

   modport source (output valid, output result_kind, output hit_channel,
                   output hit_slot, output hit_time, output absolute_stamp,
                   output any_hit_stored, output last_of_run, input ready);
   modport sink   (input valid, input result_kind, input hit_channel,
                   input hit_slot, input hit_time, input absolute_stamp,
                   input any_hit_stored, input last_of_run, output ready);
endinterface

// ===== rtl/thwgd_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// thwgd_front
// Accepts converter words, classifies them, keeps per-channel hit counts and
// the group timing state, and pushes one queue entry per word with output.
// ============================================================================
module thwgd_front (
   input  logic                   clock,
   input  logic                   reset,
   thwgd_req_if.sink              req,
   input  thwgd_pkg::cfg_type     cfg,
   output logic                   q_push,
   output thwgd_pkg::entry_type   q_entry,
   input  logic                   q_full
);

   localparam int IDX_W = thwgd_pkg::SLOT_IDX_W;

   logic                 acc;
   logic [5:0]           in_ch;
   logic [IDX_W-1:0]     in_idx;

   logic                 s_valid_ff, s_valid_in;
   logic [31:0]          s_word_ff;
   logic                 s_end_ff;
   logic [3:0]           rd_cnt_ff;
   logic                 fwd_hit_ff;
   logic [3:0]           fwd_cnt_ff;

   logic [3:0]           cnt_mem [thwgd_pkg::CHANNEL_SLOTS];

   logic                 await_ff;
   logic                 hit_seen_ff;
   logic [23:0]          roll_ff;
   logic [23:0]          grp_ff;
   logic [47:0]          prev_ff;
   logic [63:0]          k_ff;
   logic                 abs_zero_ff;
   logic [thwgd_pkg::CHANNEL_SLOTS-1:0] slot_valid_ff, slot_valid_in;

   logic                 first, restart, is_hit, ch_ok, hit_ok, go;
   logic [5:0]           s_ch;
   logic [IDX_W-1:0]     s_idx;
   logic [3:0]           cnt_raw, cnt;
   logic [23:0]          roll_eff, grp_eff;
   logic [47:0]          prev_eff, stamp;
   logic [63:0]          k_eff, k_wrap, abs_new;
   logic                 borrow, seen_new;

   assign in_ch  = req.data_word[29:24];
   assign in_idx = in_ch[IDX_W-1:0];
   assign acc    = req.valid && req.ready;

   assign first   = await_ff;
   assign restart = first && abs_zero_ff;
   assign is_hit  = s_word_ff[31];
   assign s_ch    = s_word_ff[29:24];
   assign s_idx   = s_ch[IDX_W-1:0];

   always_comb begin
      cnt_raw = fwd_hit_ff ? fwd_cnt_ff : rd_cnt_ff;
      cnt     = (first || !slot_valid_ff[s_idx]) ? 4'd0 : cnt_raw;
      ch_ok   = ({1'b0, s_ch} < cfg.channels_in_use) &&
                ({1'b0, s_ch} < thwgd_pkg::SLOTS_LIMIT);
      hit_ok  = is_hit && ch_ok && (cnt < cfg.hits_per_channel);
   end

   assign go        = s_valid_ff && (!(hit_ok || s_end_ff) || !q_full);
   assign q_push    = go && (hit_ok || s_end_ff);
   assign req.ready = !s_valid_ff || go;

   // timing: k tracks absolute_time minus previous_stamp
   always_comb begin
      roll_eff = restart ? 24'd0 : roll_ff;
      if (!is_hit && s_word_ff[31:24] == thwgd_pkg::ROLLOVER_CODE) begin
         roll_eff = s_word_ff[23:0];
      end
      grp_eff = restart ? 24'd0 : grp_ff;
      if (!is_hit && s_word_ff[31:28] == thwgd_pkg::STAMP_CODE) begin
         grp_eff = s_word_ff[23:0];
      end
      prev_eff = restart ? 48'd0 : prev_ff;
      k_eff    = restart ? 64'd0 : k_ff;
      stamp    = {roll_eff, grp_eff};
      borrow   = stamp < prev_eff;
      abs_new  = k_eff + {15'd0, borrow, stamp};
      k_wrap   = {k_eff[63:48] + {15'd0, borrow}, k_eff[47:0]};
      seen_new = (!first && hit_seen_ff) || hit_ok;
   end

   always_comb begin
      slot_valid_in = first ? '0 : slot_valid_ff;
      if (hit_ok) begin
         slot_valid_in[s_idx] = 1'b1;
      end
   end

   always_comb begin
      q_entry.has_hit        = hit_ok;
      q_entry.hit_channel    = s_ch;
      q_entry.hit_slot       = cnt;
      q_entry.hit_time       = signed'(s_word_ff[23:0]);
      q_entry.has_sum        = s_end_ff;
      q_entry.absolute_stamp = abs_new;
      q_entry.any_hit_stored = seen_new;
   end

   always_comb begin
      s_valid_in = s_valid_ff;
      if (acc) begin
         s_valid_in = 1'b1;
      end else if (go) begin
         s_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (go && hit_ok) begin
         cnt_mem[s_idx] <= cnt + 4'd1;
      end
      if (acc) begin
         rd_cnt_ff <= cnt_mem[in_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s_word_ff  <= req.data_word;
         s_end_ff   <= req.group_end;
         fwd_hit_ff <= go && hit_ok && (s_idx == in_idx);
         fwd_cnt_ff <= cnt + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff    <= 1'b0;
         await_ff      <= 1'b1;
         hit_seen_ff   <= 1'b0;
         roll_ff       <= '0;
         grp_ff        <= '0;
         prev_ff       <= '0;
         k_ff          <= '0;
         abs_zero_ff   <= 1'b1;
         slot_valid_ff <= '0;
      end else begin
         s_valid_ff <= s_valid_in;
         if (go) begin
            await_ff      <= s_end_ff;
            hit_seen_ff   <= seen_new;
            roll_ff       <= roll_eff;
            grp_ff        <= grp_eff;
            slot_valid_ff <= slot_valid_in;
            if (s_end_ff) begin
               prev_ff     <= stamp;
               k_ff        <= k_wrap;
               abs_zero_ff <= (abs_new == 64'd0);
            end else begin
               prev_ff <= prev_eff;
               k_ff    <= k_eff;
            end
         end
      end
   end

endmodule

// ===== rtl/thwgd_queue.sv =====
`timescale 1ns / 1ps
// ============================================================================
// thwgd_queue
// Small FIFO of decoded entries between the front and the back.
// ============================================================================
module thwgd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  thwgd_pkg::entry_type push_entry,
   output logic                 full,
   input  logic                 pop,
   output thwgd_pkg::entry_type head,
   output logic                 empty
);

   localparam int PW = thwgd_pkg::QPTR_W;
   localparam int CW = thwgd_pkg::QCNT_W;

   thwgd_pkg::entry_type slots [thwgd_pkg::QUEUE_DEPTH];

   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff, count_in;

   assign full  = (count_ff == CW'(thwgd_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slots[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots[wr_ptr_ff] <= push_entry;
      end
   end

   // depth is a power of two, pointers wrap naturally
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         end
      end
   end

endmodule

// ===== rtl/thwgd_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// thwgd_back
// Expands queue entries into hit and summary results behind an output
// register.
// ============================================================================
module thwgd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  thwgd_pkg::entry_type head,
   input  logic                 q_empty,
   output logic                 q_pop,
   thwgd_rsp_if.source          rsp
);

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   phase_ff, phase_in;
   thwgd_pkg::result_type  res_ff, res_in;
   logic                   out_free, load, send_hit;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign load     = out_free && !q_empty;
   assign send_hit = head.has_hit && !phase_ff;
   assign q_pop    = load && !(send_hit && head.has_sum);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      phase_in     = phase_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         phase_in     = send_hit && head.has_sum;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      res_in = '0;
      if (send_hit) begin
         res_in.result_kind = thwgd_pkg::RESULT_HIT;
         res_in.hit_channel = head.hit_channel;
         res_in.hit_slot    = head.hit_slot;
         res_in.hit_time    = head.hit_time;
         res_in.last_of_run = !head.has_sum;
      end else begin
         res_in.result_kind    = thwgd_pkg::RESULT_SUMMARY;
         res_in.absolute_stamp = head.absolute_stamp;
         res_in.any_hit_stored = head.any_hit_stored;
         res_in.last_of_run    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.result_kind    = res_ff.result_kind;
   assign rsp.hit_channel    = res_ff.hit_channel;
   assign rsp.hit_slot       = res_ff.hit_slot;
   assign rsp.hit_time       = res_ff.hit_time;
   assign rsp.absolute_stamp = res_ff.absolute_stamp;
   assign rsp.any_hit_stored = res_ff.any_hit_stored;
   assign rsp.last_of_run    = res_ff.last_of_run;

endmodule

// ===== rtl/tdc_hit_word_group_decoder.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tdc_hit_word_group_decoder
// Decodes converter event group words into per-channel hits and a group
// summary with an accumulated 64-bit absolute time.
// ============================================================================
//  Channel   Direction  Handshake          Contents
//  req_bus   in         valid/ready        data_word, group_end
//  rsp_bus   out        valid/ready        hit or group summary result
//  csr_*     in         write enable only  channels_in_use, hits_per_channel
//
//  One request per clock unless the decode stage stalls; a request with a hit
//  and group_end yields two responses and holds the response port for both.
//  A request passes the decode stage (counter memory read), the four-entry
//  queue and the output register before its first response is valid.
//  Decode stage stalls only when the queue is full; the queue fills only
//  while the response side stalls or double responses back up.
//  Synchronous reset; no clearing pass: counters use per-channel valid bits.
// ============================================================================
module tdc_hit_word_group_decoder (
   input  logic                               clock,
   input  logic                               reset,
   thwgd_req_if.sink                          req_bus,
   thwgd_rsp_if.source                        rsp_bus,
   input  logic                               csr_we,
   input  logic [thwgd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [thwgd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   thwgd_pkg::cfg_type   cfg_ff;
   thwgd_pkg::entry_type q_entry, q_head;
   logic                 q_push, q_pop, q_full, q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channels_in_use  <= thwgd_pkg::CHANNELS_RESET;
         cfg_ff.hits_per_channel <= thwgd_pkg::HITS_RESET;
      end else if (csr_we) begin
         unique case (thwgd_pkg::csr_index_type'(csr_index))
            thwgd_pkg::CSR_CHANNELS_IN_USE: begin
               cfg_ff.channels_in_use <= csr_wdata[6:0];
            end
            thwgd_pkg::CSR_HITS_PER_CHANNEL: begin
               cfg_ff.hits_per_channel <= csr_wdata[3:0];
            end
         endcase
      end
   end

   thwgd_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .cfg     (cfg_ff),
      .q_push  (q_push),
      .q_entry (q_entry),
      .q_full  (q_full)
   );

   thwgd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head       (q_head),
      .empty      (q_empty)
   );

   thwgd_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (q_head),
      .q_empty (q_empty),
      .q_pop   (q_pop),
      .rsp     (rsp_bus)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full))
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && q_empty))
      else $error("queue pop while empty");

   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.result_kind == thwgd_pkg::RESULT_SUMMARY)
      |-> rsp_bus.last_of_run)
      else $error("summary response not marked last");

   a_hit_then_summary: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.ready &&
       rsp_bus.result_kind == thwgd_pkg::RESULT_HIT && !rsp_bus.last_of_run)
      |=> (rsp_bus.valid && rsp_bus.result_kind == thwgd_pkg::RESULT_SUMMARY))
      else $error("summary did not follow its hit");

endmodule
